### src/aop_pkg.sv
// Shared types, constants and tables of the AIC onset picker.
package aop_pkg;

	localparam int AIC_W    = 32;
	localparam int POS_W    = 6;
	localparam int OUT_TDW  = ((AIC_W + POS_W + 7) / 8) * 8;
	localparam int USER_W   = 2;
	localparam int LOG_FRAC = 24;
	localparam int MANT_W   = 31;
	localparam int LN2_W    = 25;
	localparam logic signed [LN2_W-1:0] LN2_Q24 = 25'sd11629080;
	localparam logic [AIC_W-1:0] AIC_MIN = 32'h8000_0000;

	// log2 of a window count, Q.24, for counts up to 64
	localparam int LOGC_W  = 27;
	localparam int LOGC_N  = 65;
	localparam int LOGC_IW = 7;

	typedef logic [LOGC_W-1:0] logc_tbl_t [LOGC_N];

	// datapath operations, each started by a one-cycle command
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCUM,
		OP_TERM,
		OP_OUT
	} dp_op_t;

	// score store write source
	typedef enum logic [1:0] {
		WR_ZERO,
		WR_FWD,
		WR_BWD
	} wr_sel_t;

	typedef struct packed {
		dp_op_t  op;
		logic    bwd;
		logic    short_run;
		logic    smp_we;
		logic    smp_re;
		logic    scr_we;
		logic    scr_re;
		wr_sel_t wsel;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic zero;
	} dp_stat_t;

	// Build the count log table with the same square-and-compare recurrence as the datapath
	function automatic logc_tbl_t make_logc_tbl();
		logc_tbl_t          t;
		logic [63:0]        m;
		logic [LOG_FRAC-1:0] frac;
		int                 k;
		t[0] = '0;
		for (int c = 1; c < LOGC_N; c++) begin
			k = 0;
			for (int v = c; v > 1; v = v >> 1) begin
				k++;
			end
			m = 64'(c) << (30 - k);
			frac = '0;
			for (int b = 0; b < LOG_FRAC; b++) begin
				m = (m * m) >> 30;
				frac = {frac[LOG_FRAC-2:0], 1'b0};
				if (m[31]) begin
					m = m >> 1;
					frac[0] = 1'b1;
				end
			end
			t[c] = LOGC_W'(k * (1 << LOG_FRAC) + int'(frac));
		end
		return t;
	endfunction

	localparam logc_tbl_t LOGC_TBL = make_logc_tbl();

endpackage

### src/aop_ram.sv
// Generic single-port RAM with registered read.
module aop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/aop_dp.sv
// Datapath: trace and score stores, shift-add multiplier, normalizer, bit-serial log2.
module aop_dp import aop_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dp_cmd_t                        cmd,
	input  logic [$clog2(MAX_SAMPLES)-1:0] smp_addr,
	input  logic [$clog2(MAX_SAMPLES)-1:0] scr_addr,
	input  logic [SAMPLE_BITS-1:0]         smp_wdata,
	output dp_stat_t                       stat,
	output logic [AIC_W-1:0]               aic_value
);

	localparam int CNTW = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SAMPLE_BITS + CNTW;
	localparam int QW   = 2 * SAMPLE_BITS + CNTW;
	localparam int DW   = 2 * SUMW;
	localparam int MW   = SUMW;
	localparam int NRMW = (DW > MANT_W) ? DW : MANT_W;
	localparam int KW   = $clog2(NRMW);
	localparam int LOGW = KW + LOG_FRAC + 1;
	localparam int ACCW = LOGW + CNTW + 2;
	localparam int SCRW = ACCW + 1;
	localparam int PRW  = ACCW + LN2_W;
	localparam int LCW  = $clog2(LOG_FRAC);
	localparam logic signed [PRW-1:0] RND_HALF = PRW'(64'h8000_0000);
	localparam logic signed [PRW-1:0] SAT_HI = {{(PRW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [PRW-1:0] SAT_LO = {{(PRW-31){1'b1}}, 31'b0};

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SQ,
		PH_CQ,
		PH_SS,
		PH_NORM,
		PH_LOG,
		PH_WGT,
		PH_ORND
	} phase_t;

	phase_t                  phase_q;
	logic signed [SUMW-1:0]  sum_q;
	logic [QW-1:0]           sqsum_q;
	logic [CNTW-1:0]         cnt_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [DW-1:0]           mcand_q;
	logic [MW-1:0]           mplier_q;
	logic [DW-1:0]           prod_q;
	logic [DW-1:0]           cq_q;
	logic [NRMW-1:0]         nrm_q;
	logic [KW-1:0]           k_q;
	logic [MANT_W-1:0]       mant_q;
	logic [LOG_FRAC-1:0]     frac_q;
	logic [LCW-1:0]          lcnt_q;
	logic                    bwd_q;
	logic                    short_q;
	logic signed [ACCW-1:0]  term_q;
	logic                    tzero_q;
	logic signed [PRW-1:0]   oprod_q;
	logic                    ozero_q;
	logic [AIC_W-1:0]        aic_q;
	logic                    done_q;

	logic [SAMPLE_BITS-1:0]  smp_rd;
	logic [SCRW-1:0]         scr_rd;
	logic [SCRW-1:0]         scr_wdata;
	logic signed [ACCW-1:0]  scr_acc;
	logic signed [SAMPLE_BITS:0] x_ext;
	logic signed [SAMPLE_BITS:0] x_abs;
	logic [MW-1:0]           x_mag;
	logic signed [SUMW-1:0]  sum_neg;
	logic [MW-1:0]           s_mag;
	logic [DW-1:0]           mul_next;
	logic [DW-1:0]           d_val;
	logic [2*MANT_W-1:0]     msq;
	logic [LOGC_W-1:0]       logc;
	logic signed [LOGW-1:0]  ldiff;
	logic [CNTW-1:0]         weight;
	logic signed [CNTW+LOGW:0] wprod;
	logic signed [PRW-1:0]   orn;
	logic signed [PRW-1:0]   osh;
	logic [AIC_W-1:0]        osat;

	aop_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_smp_ram (
		.clk   (clk),
		.we    (cmd.smp_we),
		.re    (cmd.smp_re),
		.addr  (smp_addr),
		.wdata (smp_wdata),
		.rdata (smp_rd)
	);

	aop_ram #(.WIDTH(SCRW), .DEPTH(MAX_SAMPLES)) u_scr_ram (
		.clk   (clk),
		.we    (cmd.scr_we),
		.re    (cmd.scr_re),
		.addr  (scr_addr),
		.wdata (scr_wdata),
		.rdata (scr_rd)
	);

	assign scr_acc = $signed(scr_rd[ACCW-1:0]);

	// score write: forward term, zero, or accumulate backward term
	always_comb begin
		case (cmd.wsel)
			WR_FWD:  scr_wdata = {tzero_q, term_q};
			WR_BWD:  scr_wdata = {scr_rd[ACCW] | tzero_q, scr_acc + term_q};
			default: scr_wdata = '0;
		endcase
	end

	// operand magnitudes and one multiplier step
	always_comb begin
		x_ext    = {smp_rd[SAMPLE_BITS-1], smp_rd};
		x_abs    = x_ext[SAMPLE_BITS] ? -x_ext : x_ext;
		x_mag    = MW'($unsigned(x_abs));
		sum_neg  = -sum_q;
		s_mag    = sum_q[SUMW-1] ? $unsigned(sum_neg) : $unsigned(sum_q);
		mul_next = prod_q + (mplier_q[0] ? mcand_q : '0);
		d_val    = cq_q - prod_q;
		msq      = mant_q * mant_q;
	end

	// weighted log term and output rounding
	always_comb begin
		logc   = LOGC_TBL[LOGC_IW'(cnt_q)];
		ldiff  = $signed(LOGW'({k_q, frac_q})) - $signed(LOGW'({logc, 1'b0}));
		weight = bwd_q ? cnt_q - CNTW'(1) : cnt_q;
		wprod  = $signed({1'b0, weight}) * ldiff;
		orn    = oprod_q + RND_HALF;
		osh    = orn >>> 32;
		if (osh > SAT_HI) begin
			osat = {1'b0, {(AIC_W-1){1'b1}}};
		end else if (osh < SAT_LO) begin
			osat = AIC_MIN;
		end else begin
			osat = osh[AIC_W-1:0];
		end
	end

	// operation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					// the done pulse lasts the one idle cycle after an operation
					done_q <= 1'b0;
					case (cmd.op)
						OP_CLEAR: begin
							sum_q   <= '0;
							sqsum_q <= '0;
							cnt_q   <= '0;
						end
						OP_ACCUM: begin
							x_q      <= $signed(smp_rd);
							mcand_q  <= DW'(x_mag);
							mplier_q <= x_mag;
							prod_q   <= '0;
							phase_q  <= PH_SQ;
						end
						OP_TERM: begin
							bwd_q    <= cmd.bwd;
							mcand_q  <= DW'(sqsum_q);
							mplier_q <= MW'(cnt_q);
							prod_q   <= '0;
							phase_q  <= PH_CQ;
						end
						OP_OUT: begin
							short_q <= cmd.short_run;
							ozero_q <= !cmd.short_run && scr_rd[ACCW];
							oprod_q <= scr_acc * LN2_Q24;
							phase_q <= PH_ORND;
						end
						default: ;
					endcase
				end
				PH_SQ: begin
					if (mplier_q != '0) begin
						prod_q   <= mul_next;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end else begin
						sqsum_q <= sqsum_q + QW'(prod_q);
						sum_q   <= sum_q + SUMW'(x_q);
						cnt_q   <= cnt_q + CNTW'(1);
						done_q  <= 1'b1;
						phase_q <= PH_IDLE;
					end
				end
				PH_CQ: begin
					if (mplier_q != '0) begin
						prod_q   <= mul_next;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end else begin
						cq_q     <= prod_q;
						mcand_q  <= DW'(s_mag);
						mplier_q <= s_mag;
						prod_q   <= '0;
						phase_q  <= PH_SS;
					end
				end
				PH_SS: begin
					if (mplier_q != '0) begin
						prod_q   <= mul_next;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end else if (d_val == '0) begin
						tzero_q <= 1'b1;
						term_q  <= '0;
						done_q  <= 1'b1;
						phase_q <= PH_IDLE;
					end else begin
						tzero_q <= 1'b0;
						nrm_q   <= NRMW'(d_val);
						k_q     <= KW'(NRMW - 1);
						phase_q <= PH_NORM;
					end
				end
				PH_NORM: begin
					// shift until the top bit is set; k tracks its index
					if (!nrm_q[NRMW-1]) begin
						nrm_q <= nrm_q << 1;
						k_q   <= k_q - KW'(1);
					end else begin
						mant_q  <= nrm_q[NRMW-1 -: MANT_W];
						frac_q  <= '0;
						lcnt_q  <= '0;
						phase_q <= PH_LOG;
					end
				end
				PH_LOG: begin
					// square the mantissa, emit one fraction bit
					if (msq[2*MANT_W-1]) begin
						mant_q <= msq[2*MANT_W-1 -: MANT_W];
						frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
					end else begin
						mant_q <= msq[2*MANT_W-2 -: MANT_W];
						frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
					end
					lcnt_q <= lcnt_q + LCW'(1);
					if (lcnt_q == LCW'(LOG_FRAC - 1)) begin
						phase_q <= PH_WGT;
					end
				end
				PH_WGT: begin
					term_q  <= ACCW'(wprod);
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				PH_ORND: begin
					if (short_q) begin
						aic_q <= '0;
					end else if (ozero_q) begin
						aic_q <= AIC_MIN;
					end else begin
						aic_q <= osat;
					end
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.zero = ozero_q;
	assign aic_value = aic_q;

endmodule

### src/aop_ctrl.sv
// Controller: trace collection, forward and backward passes, score emission.
module aop_ctrl import aop_pkg::*; #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [$clog2(MAX_SAMPLES)-1:0] position,
	output logic                           run_end,
	output logic                           trunc,
	output dp_cmd_t                        cmd,
	output logic [$clog2(MAX_SAMPLES)-1:0] smp_addr,
	output logic [$clog2(MAX_SAMPLES)-1:0] scr_addr,
	input  dp_stat_t                       stat
);

	localparam int CNTW = $clog2(MAX_SAMPLES + 1);
	localparam int IDXW = $clog2(MAX_SAMPLES);

	typedef enum logic [4:0] {
		ST_COLLECT,
		ST_START,
		ST_F_RD,
		ST_F_ACC,
		ST_F_AW,
		ST_F_TERM,
		ST_F_TW,
		ST_F_WR,
		ST_B_INIT,
		ST_B_RD,
		ST_B_ACC,
		ST_B_AW,
		ST_B_TERM,
		ST_B_TW,
		ST_B_WR,
		ST_OUT_RD,
		ST_OUT_GO,
		ST_OUT_W,
		ST_OUT_SEND
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] fill_q;
	logic [CNTW-1:0] n_q;
	logic [IDXW-1:0] p_q;
	logic [IDXW-1:0] qi_q;
	logic            ovf_q;
	logic            m_valid_q;

	logic            room;
	logic            beat_in;
	logic            short_run;
	logic [IDXW-1:0] n_m1;
	logic [IDXW-1:0] n_m2;

	assign room      = fill_q < CNTW'(MAX_SAMPLES);
	assign beat_in   = s_tvalid && s_tready;
	assign short_run = n_q <= CNTW'(2);
	assign n_m1      = IDXW'(n_q - CNTW'(1));
	assign n_m2      = IDXW'(n_q - CNTW'(2));

	// decode commands and addresses from the state
	always_comb begin
		cmd           = '0;
		cmd.op        = OP_NONE;
		cmd.wsel      = WR_ZERO;
		cmd.short_run = short_run;
		smp_addr      = p_q;
		scr_addr      = p_q;
		unique case (state_q)
			ST_COLLECT: begin
				smp_addr   = fill_q[IDXW-1:0];
				cmd.smp_we = beat_in && room;
			end
			ST_START:  cmd.op = OP_CLEAR;
			ST_F_RD:   cmd.smp_re = 1'b1;
			ST_F_ACC:  cmd.op = OP_ACCUM;
			ST_F_TERM: cmd.op = OP_TERM;
			ST_F_WR: begin
				cmd.scr_we = 1'b1;
				cmd.wsel   = (p_q == '0) ? WR_ZERO : WR_FWD;
			end
			ST_B_INIT: cmd.op = OP_CLEAR;
			ST_B_RD: begin
				cmd.smp_re = 1'b1;
				cmd.scr_re = 1'b1;
				scr_addr   = p_q - IDXW'(1);
			end
			ST_B_ACC: cmd.op = OP_ACCUM;
			ST_B_TERM: begin
				cmd.op  = OP_TERM;
				cmd.bwd = 1'b1;
			end
			ST_B_WR: begin
				cmd.scr_we = 1'b1;
				cmd.wsel   = WR_BWD;
				scr_addr   = p_q - IDXW'(1);
			end
			ST_OUT_RD: begin
				cmd.scr_re = 1'b1;
				scr_addr   = (qi_q > n_m2) ? n_m2 : qi_q;
			end
			ST_OUT_GO: cmd.op = OP_OUT;
			default: ;
		endcase
	end

	// sequence the trace through collection, both passes and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			fill_q    <= '0;
			n_q       <= '0;
			p_q       <= '0;
			qi_q      <= '0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (beat_in) begin
						if (room) begin
							fill_q <= fill_q + CNTW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							n_q     <= room ? fill_q + CNTW'(1) : fill_q;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					p_q     <= '0;
					qi_q    <= '0;
					state_q <= short_run ? ST_OUT_RD : ST_F_RD;
				end
				ST_F_RD:   state_q <= ST_F_ACC;
				ST_F_ACC:  state_q <= ST_F_AW;
				ST_F_AW: begin
					if (stat.done) begin
						state_q <= (p_q == '0) ? ST_F_WR : ST_F_TERM;
					end
				end
				ST_F_TERM: state_q <= ST_F_TW;
				ST_F_TW: begin
					if (stat.done) begin
						state_q <= ST_F_WR;
					end
				end
				ST_F_WR: begin
					if (p_q == n_m2) begin
						p_q     <= n_m1;
						state_q <= ST_B_INIT;
					end else begin
						p_q     <= p_q + IDXW'(1);
						state_q <= ST_F_RD;
					end
				end
				ST_B_INIT: state_q <= ST_B_RD;
				ST_B_RD:   state_q <= ST_B_ACC;
				ST_B_ACC:  state_q <= ST_B_AW;
				ST_B_AW: begin
					if (stat.done) begin
						if (p_q == n_m1) begin
							p_q     <= n_m2;
							state_q <= ST_B_RD;
						end else begin
							state_q <= ST_B_TERM;
						end
					end
				end
				ST_B_TERM: state_q <= ST_B_TW;
				ST_B_TW: begin
					if (stat.done) begin
						state_q <= ST_B_WR;
					end
				end
				ST_B_WR: begin
					if (p_q == IDXW'(1)) begin
						qi_q    <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						p_q     <= p_q - IDXW'(1);
						state_q <= ST_B_RD;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_GO;
				ST_OUT_GO: state_q <= ST_OUT_W;
				ST_OUT_W: begin
					if (stat.done) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_OUT_SEND;
					end
				end
				ST_OUT_SEND: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (qi_q == n_m1) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_COLLECT;
						end else begin
							qi_q    <= qi_q + IDXW'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	assign s_tready = (state_q == ST_COLLECT);
	assign m_tvalid = m_valid_q;
	assign position = qi_q;
	assign run_end  = (qi_q == n_m1);
	assign trunc    = ovf_q;

endmodule

### src/aic_onset_picker.sv
// Top level of the AIC onset picker: stream ports, controller and datapath.
//
// Samples arrive one beat per cycle and are stored until the beat with tlast;
// beats beyond MAX_SAMPLES are dropped and reported through the truncated flag.
// The trace is then scored in a forward and a backward pass, one stored sample
// at a time, and one score beat per stored sample follows, in order, with tlast
// on the final one. No input beat is taken from the closing beat until the final
// score beat is accepted. Scoring runs, per sample and pass, up to three products
// on a bit-per-cycle shift-add multiplier (stopping at the top set bit of the
// multiplier), a leading-zero shift and 24 squaring steps of the log2 unit. Each
// score beat is read from the score store and rounded, then held until m_tready.
// Traces of two samples or fewer skip both passes and return zero scores.
module aic_onset_picker import aop_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
	input  logic                                 s_tlast,   // last_sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [OUT_TDW-1:0]                   m_tdata,   // aic_value, position
	output logic [USER_W-1:0]                    m_tuser,   // log_of_zero, truncated
	output logic                                 m_tlast    // end_of_run
);

	localparam int IDXW = $clog2(MAX_SAMPLES);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDXW-1:0]  smp_addr;
	logic [IDXW-1:0]  scr_addr;
	logic [IDXW-1:0]  position;
	logic             run_end;
	logic             trunc;
	logic [AIC_W-1:0] aic_value;

	aop_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.position (position),
		.run_end  (run_end),
		.trunc    (trunc),
		.cmd      (cmd),
		.smp_addr (smp_addr),
		.scr_addr (scr_addr),
		.stat     (stat)
	);

	aop_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.smp_addr  (smp_addr),
		.scr_addr  (scr_addr),
		.smp_wdata (s_tdata[SAMPLE_BITS-1:0]),
		.stat      (stat),
		.aic_value (aic_value)
	);

	// pack the score beat
	assign m_tdata = {{(OUT_TDW-AIC_W-POS_W){1'b0}}, POS_W'(position), aic_value};
	assign m_tuser = {trunc, stat.zero};
	assign m_tlast = run_end;

`ifndef ASSERT_OFF
	// the block never collects and emits at the same time
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("score beat offered while collecting");

	// the final score beat hands the block back to collection
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("collection not resumed after final score");

	// a saturated zero-variance score carries the minimum value
	a_zero_min: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[AIC_W-1:0] == AIC_MIN))
		else $error("zero-variance flag without minimum score");
`endif

endmodule

### tb/tb_aic_onset_picker.sv
// Self-checking stream testbench for the AIC onset picker top level.
`timescale 1ns / 1ps

module tb_aic_onset_picker;
	import aop_pkg::*;

	localparam int NSAMP    = 64;
	localparam int SBITS    = 24;
	localparam int IDLE_MAX = 200000;
	localparam int HOLD_LEN = 3000;

	typedef enum int {
		TR_RANDOM,
		TR_FLAT,
		TR_SMALL,
		TR_EXTREME
	} trace_kind_t;

	typedef struct {
		logic [SBITS-1:0] smp;
		logic             last;
	} sample_beat_t;

	typedef struct {
		logic [AIC_W-1:0] aic;
		logic [POS_W-1:0] pos;
		logic             eor;
		logic             zero;
		logic             trunc;
	} score_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [SBITS-1:0]       s_tdata;   // sample
	logic                   s_tlast;   // last_sample
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDW-1:0]     m_tdata;   // aic_value, position
	logic [USER_W-1:0]      m_tuser;   // log_of_zero, truncated
	logic                   m_tlast;   // end_of_run

	sample_beat_t           pending_q[$];
	score_beat_t            score_q[$];
	logic signed [SBITS-1:0] trace_buf[$];
	bit                     trace_ovf;
	bit                     calm;
	int                     errors;
	int                     scores_seen;
	int                     traces_done;
	int                     trunc_traces;
	int                     zero_scores;
	int                     idle_cycles;
	int                     send_gap;
	int                     recv_gap;
	int                     hold_left;
	bit                     hold_done;

	aic_onset_picker #(.MAX_SAMPLES(NSAMP), .SAMPLE_BITS(SBITS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// log2 of a positive integer in Q.24, square-and-compare on a 31-bit mantissa
	function automatic longint log2_q24(input logic [127:0] v);
		int           k;
		logic [127:0] t;
		logic [63:0]  m;
		longint       frac;
		k = 0;
		for (int i = 0; i < 128; i++)
			if (v[i]) k = i;
		t = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
		m = {33'd0, t[30:0]};
		frac = 0;
		for (int b = 0; b < LOG_FRAC; b++) begin
			m = (m * m) >> 30;
			frac = frac * 2;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac = frac + 1;
			end
		end
		return longint'(k) * (longint'(1) << LOG_FRAC) + frac;
	endfunction

	// add weight*log2(variance) of a window; return 1 when the variance is zero
	function automatic bit add_window_term(input int c, input longint w, input longint s,
			input logic [127:0] q, inout longint acc);
		logic [127:0] mag;
		logic [127:0] d;
		mag = (s < 0) ? 128'(-s) : 128'(s);
		d = q * 128'(c) - mag * mag;
		if (d == 0) return 1'b1;
		acc += w * (log2_q24(d) - 2 * log2_q24(128'(c)));
		return 1'b0;
	endfunction

	// score the closed trace and queue one expected beat per stored sample
	task automatic score_trace();
		int           n;
		longint       acc[NSAMP];
		bit           zf[NSAMP];
		longint       sum;
		logic [127:0] sq;
		longint       mag;
		longint       prod;
		longint       v;
		score_beat_t  e;
		n = trace_buf.size();
		for (int p = 0; p < n; p++) begin
			acc[p] = 0;
			zf[p] = 1'b0;
		end
		if (n > 2) begin
			// forward pass over prefixes
			sum = 0;
			sq = 0;
			for (int p = 0; p + 1 < n; p++) begin
				mag = trace_buf[p];
				sum += mag;
				sq += 128'(mag < 0 ? -mag : mag) * 128'(mag < 0 ? -mag : mag);
				if (p >= 1 && add_window_term(p + 1, p + 1, sum, sq, acc[p])) zf[p] = 1'b1;
			end
			// backward pass over suffixes
			sum = 0;
			sq = 0;
			for (int p = n - 1; p >= 1; p--) begin
				mag = trace_buf[p];
				sum += mag;
				sq += 128'(mag < 0 ? -mag : mag) * 128'(mag < 0 ? -mag : mag);
				if (p <= n - 2 && add_window_term(n - p, n - p - 1, sum, sq, acc[p - 1]))
					zf[p - 1] = 1'b1;
			end
			acc[n - 1] = acc[n - 2];
			zf[n - 1] = zf[n - 2];
		end
		for (int p = 0; p < n; p++) begin
			if (zf[p]) begin
				v = -64'sd2147483648;
			end else begin
				prod = acc[p] * longint'(LN2_Q24) + (longint'(1) << 31);
				v = prod >>> 32;
				if (v > 64'sd2147483647) v = 64'sd2147483647;
				if (v < -64'sd2147483648) v = -64'sd2147483648;
			end
			e.aic = v[AIC_W-1:0];
			e.pos = p[POS_W-1:0];
			e.eor = (p == n - 1);
			e.zero = zf[p];
			e.trunc = trace_ovf;
			score_q.push_back(e);
		end
		traces_done++;
		if (trace_ovf) trunc_traces++;
		trace_buf.delete();
		trace_ovf = 1'b0;
	endtask

	// fold one accepted sample beat into the trace
	task automatic take_sample(input logic [SBITS-1:0] smp, input logic last);
		if (trace_buf.size() < NSAMP) trace_buf.push_back(smp);
		else trace_ovf = 1'b1;
		if (last) score_trace();
	endtask

	task automatic add_trace(input int len, input trace_kind_t kind);
		sample_beat_t b;
		logic [SBITS-1:0] base;
		base = SBITS'($urandom);
		for (int i = 0; i < len; i++) begin
			case (kind)
				TR_FLAT:    b.smp = base;
				TR_SMALL:   b.smp = SBITS'($urandom_range(0, 4) - 2);
				TR_EXTREME: b.smp = ($urandom_range(0, 1) != 0) ? 24'h7F_FFFF : 24'h80_0000;
				default:    b.smp = SBITS'($urandom);
			endcase
			b.last = (i == len - 1);
			pending_q.push_back(b);
		end
	endtask

	task automatic add_fixed(input logic [SBITS-1:0] smp, input logic last);
		sample_beat_t b;
		b.smp = smp;
		b.last = last;
		pending_q.push_back(b);
	endtask

	// driver: present beats from the pending queue, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) take_sample(s_tdata, s_tlast);
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				s_tdata <= pending_q[0].smp;
				s_tlast <= pending_q[0].last;
				s_tvalid <= 1'b1;
				void'(pending_q.pop_front());
				if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 17);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check each score beat, stall at random, hold off once for long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (score_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected score beat pos=%0d", m_tdata[37:32]);
				end else begin
					if (m_tdata[31:0] !== score_q[0].aic || m_tdata[37:32] !== score_q[0].pos
							|| m_tlast !== score_q[0].eor || m_tuser[0] !== score_q[0].zero
							|| m_tuser[1] !== score_q[0].trunc) begin
						errors++;
						if (errors <= 10)
							$display("score mismatch: exp aic=%h pos=%0d last=%b zero=%b trunc=%b, got aic=%h pos=%0d last=%b zero=%b trunc=%b",
								score_q[0].aic, score_q[0].pos, score_q[0].eor, score_q[0].zero,
								score_q[0].trunc, m_tdata[31:0], m_tdata[37:32], m_tlast,
								m_tuser[0], m_tuser[1]);
					end
					if (score_q[0].zero) zero_scores++;
					void'(score_q.pop_front());
				end
				scores_seen++;
			end
			if (!hold_done && scores_seen >= 40) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 17);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int pushed;
		int len;
		bit long_done;
		errors = 0;
		scores_seen = 0;
		traces_done = 0;
		trunc_traces = 0;
		zero_scores = 0;
		idle_cycles = 0;
		trace_ovf = 1'b0;
		calm = 1'b0;
		arst_n = 1'b0;

		// directed: single, pair, extremes, flat and tiny-variance traces
		add_fixed(24'h7F_FFFF, 1'b1);
		add_fixed(24'h80_0000, 1'b0);
		add_fixed(24'h7F_FFFF, 1'b1);
		add_fixed(24'h80_0000, 1'b0);
		add_fixed(24'h7F_FFFF, 1'b0);
		add_fixed(24'h80_0000, 1'b1);
		add_trace(4, TR_FLAT);
		add_fixed(24'h00_0000, 1'b0);
		add_fixed(24'hFF_FFFF, 1'b0);
		add_fixed(24'h7F_FFFF, 1'b0);
		add_fixed(24'h80_0000, 1'b0);
		add_fixed(24'h00_0000, 1'b1);
		add_trace(5, TR_SMALL);
		add_trace(3, TR_FLAT);

		// random traces, mostly short, a few full and one overfull
		pushed = 0;
		long_done = 1'b0;
		while (pushed < 340) begin
			if (!long_done && pushed > 150) begin
				len = 70;
				long_done = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				len = NSAMP;
			end else begin
				len = $urandom_range(1, 16);
			end
			add_trace(len, trace_kind_t'($urandom_range(0, 7) < 5 ? TR_RANDOM :
				$urandom_range(1, 3)));
			pushed += len;
		end
		add_trace(6, TR_RANDOM);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() > 40) @(posedge clk);
		calm = 1'b1;
		while (pending_q.size() > 0 || s_tvalid) @(posedge clk);
		while (score_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Covered %0d traces (%0d truncated), %0d score beats, %0d zero-variance scores.",
			traces_done, trunc_traces, scores_seen, zero_scores);
		$display("Mismatches: %0d", errors);
		if (errors == 0 && score_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
